@@ src/bvcg_pkg.sv @@
package bvcg_pkg;

  localparam int IDX_W = 7;
  localparam int CH_W = 8;
  localparam int NUM_CH = 4;
  localparam int COLOR_W = NUM_CH * CH_W;
  // Widths hold for division counts up to 127; VNUM_W only for counts to 89.
  localparam int EDGE_W = 15;
  localparam int PROD_W = 14;
  localparam int NUM_W = 22;
  localparam int VNUM_FULL_W = 15;
  localparam int VNUM_W = 13;
  localparam int DIV_STEPS = CH_W;
  localparam int CFG_IDX_W = 3;
  localparam int DEF_MAX_DIVISIONS = 64;

  localparam logic [COLOR_W-1:0] COLOR_RESET = '1;
  localparam logic [IDX_W-1:0] DIV_RESET = IDX_W'(1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CORNER0   = 3'd0,
    REG_CORNER1   = 3'd1,
    REG_CORNER2   = 3'd2,
    REG_CORNER3   = 3'd3,
    REG_OUTER_DIV = 3'd4,
    REG_INNER_DIV = 3'd5
  } cfg_reg_t;

  typedef logic [NUM_W-1:0] num_t;
  typedef logic [EDGE_W-1:0] edge_t;
  typedef logic [CH_W-1:0] chan_t;
  typedef num_t [NUM_CH-1:0] num_vec_t;
  typedef edge_t [NUM_CH-1:0] edge_vec_t;
  typedef chan_t [NUM_CH-1:0] chan_vec_t;

  typedef struct packed {
    logic [VNUM_W-1:0] vnum;
    logic              in_range;
  } side_t;

endpackage

@@ src/bvcg_divider.sv @@
module bvcg_divider (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  bvcg_pkg::num_vec_t          numer,
  input  logic [bvcg_pkg::PROD_W-1:0] divisor,
  input  bvcg_pkg::side_t             side_in,
  output logic                        out_valid,
  input  logic                        out_ready,
  output bvcg_pkg::chan_vec_t         quot,
  output bvcg_pkg::side_t             side_out
);
  import bvcg_pkg::*;

  // One restoring step per stage; stage s resolves quotient bit DIV_STEPS-1-s
  // for all four channels at once.
  logic [DIV_STEPS-1:0] vld;
  logic [DIV_STEPS:0]   ld;
  num_vec_t             rem      [DIV_STEPS];
  chan_vec_t            quo      [DIV_STEPS];
  logic [PROD_W-1:0]    dv       [DIV_STEPS];
  side_t                sd       [DIV_STEPS];

  logic [DIV_STEPS-1:0] v_in;
  num_vec_t             rem_in   [DIV_STEPS];
  chan_vec_t            quo_in   [DIV_STEPS];
  logic [PROD_W-1:0]    dv_in    [DIV_STEPS];
  side_t                sd_in    [DIV_STEPS];
  num_vec_t             rem_out  [DIV_STEPS];
  chan_vec_t            quo_out  [DIV_STEPS];

  always_comb begin
    v_in[0]   = in_valid;
    rem_in[0] = numer;
    quo_in[0] = '0;
    dv_in[0]  = divisor;
    sd_in[0]  = side_in;
    for (int s = 1; s < DIV_STEPS; s++) begin
      v_in[s]   = vld[s-1];
      rem_in[s] = rem[s-1];
      quo_in[s] = quo[s-1];
      dv_in[s]  = dv[s-1];
      sd_in[s]  = sd[s-1];
    end
  end

  // A stage may load when it is empty or its word moves on this cycle.
  always_comb begin
    ld[DIV_STEPS] = out_ready;
    for (int s = DIV_STEPS - 1; s >= 0; s--) begin
      ld[s] = !vld[s] || ld[s+1];
    end
  end

  always_comb begin
    num_t dsh;
    for (int s = 0; s < DIV_STEPS; s++) begin
      dsh = num_t'(dv_in[s]) << (DIV_STEPS - 1 - s);
      for (int c = 0; c < NUM_CH; c++) begin
        if (rem_in[s][c] >= dsh) begin
          rem_out[s][c] = rem_in[s][c] - dsh;
          quo_out[s][c] = {quo_in[s][c][CH_W-2:0], 1'b1};
        end else begin
          rem_out[s][c] = rem_in[s][c];
          quo_out[s][c] = {quo_in[s][c][CH_W-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int s = 0; s < DIV_STEPS; s++) begin
        if (ld[s]) begin
          vld[s] <= v_in[s];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < DIV_STEPS; s++) begin
      if (ld[s]) begin
        rem[s] <= rem_out[s];
        quo[s] <= quo_out[s];
        dv[s]  <= dv_in[s];
        sd[s]  <= sd_in[s];
      end
    end
  end

  assign in_ready  = ld[0];
  assign out_valid = vld[DIV_STEPS-1];
  assign quot      = quo[DIV_STEPS-1];
  assign side_out  = sd[DIV_STEPS-1];

endmodule

@@ src/bilinear_vertex_color_gradient.sv @@
// Bilinear vertex color for a W by H grid mesh. Each input word names a vertex
// (outer index i, inner index j) and yields one output word: the ARGB color,
// each 8-bit channel the exact floor of the bilinear blend of the four corner
// colors, the vertex number i*(H+1)+j, and an in_range flag (color and number
// are 0 when i>W or j>H). The block takes one vertex per clock while the output
// is not held, and passes it through setup, edge and numerator multiply stages,
// then eight stages of a restoring divider that settles one quotient bit per stage
// for all four channels. Each stage stalls independently, so empty slots
// collapse when the output is held. Division counts of 0 read as 1 and counts
// above MAX_DIVISIONS saturate. Write the configuration registers only while
// no vertex is in flight; cfg_ready is always high.
module bilinear_vertex_color_gradient #(
  parameter int MAX_DIVISIONS = bvcg_pkg::DEF_MAX_DIVISIONS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bvcg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bvcg_pkg::COLOR_W-1:0]   cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [bvcg_pkg::IDX_W-1:0]     outer_index,
  input  logic [bvcg_pkg::IDX_W-1:0]     inner_index,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [bvcg_pkg::COLOR_W-1:0]   vertex_color,
  output logic [bvcg_pkg::VNUM_W-1:0]    vertex_number,
  output logic                           in_range
);
  import bvcg_pkg::*;

  function automatic logic [IDX_W-1:0] eff_div(input logic [IDX_W-1:0] d);
    logic [IDX_W-1:0] r;
    if (d == '0) begin
      r = IDX_W'(1);
    end else if (int'(d) > MAX_DIVISIONS) begin
      r = IDX_W'(MAX_DIVISIONS);
    end else begin
      r = d;
    end
    return r;
  endfunction

  // Configuration registers.
  logic [COLOR_W-1:0] corner [NUM_CH];
  logic [IDX_W-1:0]   outer_div;
  logic [IDX_W-1:0]   inner_div;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_CH; k++) begin
        corner[k] <= COLOR_RESET;
      end
      outer_div <= DIV_RESET;
      inner_div <= DIV_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CORNER0:   corner[0] <= cfg_data;
        REG_CORNER1:   corner[1] <= cfg_data;
        REG_CORNER2:   corner[2] <= cfg_data;
        REG_CORNER3:   corner[3] <= cfg_data;
        REG_OUTER_DIV: outer_div <= cfg_data[IDX_W-1:0];
        REG_INNER_DIV: inner_div <= cfg_data[IDX_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline handshake.
  logic v1, v2, v3;
  logic ld1, ld2, ld3;
  logic div_ready;

  assign ld3      = !v3 || div_ready;
  assign ld2      = !v2 || ld3;
  assign ld1      = !v1 || ld2;
  assign in_ready = ld1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (ld1) begin
        v1 <= in_valid;
      end
      if (ld2) begin
        v2 <= v1;
      end
      if (ld3) begin
        v3 <= v2;
      end
    end
  end

  // Stage 1: range check, complements, divisor and vertex number.
  logic [IDX_W-1:0]       w_eff, h_eff;
  logic                   ok;
  logic [VNUM_FULL_W-1:0] vn_full;

  assign w_eff   = eff_div(outer_div);
  assign h_eff   = eff_div(inner_div);
  assign ok      = (outer_index <= w_eff) && (inner_index <= h_eff);
  assign vn_full = VNUM_FULL_W'(outer_index) * (VNUM_FULL_W'(h_eff) + VNUM_FULL_W'(1))
                 + VNUM_FULL_W'(inner_index);

  logic [IDX_W-1:0]  s1_i, s1_j, s1_wi, s1_hj;
  logic [PROD_W-1:0] s1_prod;
  side_t             s1_side;

  always_ff @(posedge clk) begin
    if (ld1) begin
      s1_i             <= outer_index;
      s1_j             <= inner_index;
      s1_wi            <= w_eff - outer_index;
      s1_hj            <= h_eff - inner_index;
      s1_prod          <= PROD_W'(w_eff) * PROD_W'(h_eff);
      s1_side.in_range <= ok;
      s1_side.vnum     <= ok ? vn_full[VNUM_W-1:0] : '0;
    end
  end

  // Stage 2: both edges per channel, interpolated along the outer index.
  edge_vec_t edge_a, edge_b;

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      edge_a[c] = EDGE_W'(corner[0][c*CH_W +: CH_W]) * EDGE_W'(s1_wi)
                + EDGE_W'(corner[1][c*CH_W +: CH_W]) * EDGE_W'(s1_i);
      edge_b[c] = EDGE_W'(corner[3][c*CH_W +: CH_W]) * EDGE_W'(s1_wi)
                + EDGE_W'(corner[2][c*CH_W +: CH_W]) * EDGE_W'(s1_i);
    end
  end

  edge_vec_t         s2_ea, s2_eb;
  logic [IDX_W-1:0]  s2_j, s2_hj;
  logic [PROD_W-1:0] s2_prod;
  side_t             s2_side;

  always_ff @(posedge clk) begin
    if (ld2) begin
      s2_ea   <= edge_a;
      s2_eb   <= edge_b;
      s2_j    <= s1_j;
      s2_hj   <= s1_hj;
      s2_prod <= s1_prod;
      s2_side <= s1_side;
    end
  end

  // Stage 3: blend the edges along the inner index.
  num_vec_t num;

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      num[c] = num_t'(s2_ea[c]) * num_t'(s2_hj) + num_t'(s2_eb[c]) * num_t'(s2_j);
    end
  end

  num_vec_t          s3_num;
  logic [PROD_W-1:0] s3_prod;
  side_t             s3_side;

  always_ff @(posedge clk) begin
    if (ld3) begin
      s3_num  <= num;
      s3_prod <= s2_prod;
      s3_side <= s2_side;
    end
  end

  chan_vec_t quot;
  side_t     side_out;

  bvcg_divider u_divider (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v3),
    .in_ready  (div_ready),
    .numer     (s3_num),
    .divisor   (s3_prod),
    .side_in   (s3_side),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .quot      (quot),
    .side_out  (side_out)
  );

  assign vertex_color  = side_out.in_range ? COLOR_W'(quot) : '0;
  assign vertex_number = side_out.vnum;
  assign in_range      = side_out.in_range;

endmodule
